### design/rbi_pkg.sv
// Shared types, constants and command structs for the rectilinear bilinear interpolator.
// No dependencies; used by the controller, the datapath and the top level.
package rbi_pkg;

  localparam int MaxXDef      = 64;
  localparam int MaxYDef      = 64;
  localparam int NumFieldsDef = 6;

  localparam int CountW = 7;
  localparam int IdxW   = 6;
  localparam int VarW   = 3;
  localparam int ValW   = 32;
  localparam int CrdW   = 24;

  // Request operation codes.
  localparam logic [1:0] OpLoadX  = 2'd0;
  localparam logic [1:0] OpLoadY  = 2'd1;
  localparam logic [1:0] OpLoadV  = 2'd2;
  localparam logic [1:0] OpInterp = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] CfgXCount = 1'b0;
  localparam logic [0:0] CfgYCount = 1'b1;

  // Datapath command from the controller.
  typedef struct packed {
    logic capture;    // latch the request
    logic do_load;    // perform the load write
    logic scan_start; // reset the bracket scan
    logic scan_step;  // compare one pair, issue coordinate reads
    logic div_start;  // start both fraction divisions
    logic div_step;   // one quotient bit
    logic rd_corner;  // issue a corner read
    logic [1:0] corner;
    logic lerp_row;   // blend one row or column
    logic [1:0] lerp_sel;
    logic fail;       // produce an out-of-range result
    logic finish;     // produce the blended result
  } rbi_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic is_query;
    logic var_ok;
    logic scan_done;
    logic found_both;
    logic div_done;
  } rbi_sts_t;

endpackage

### design/rbi_ctrl.sv
// Controller state machine of the interpolator: sequences loads and queries.
// Depends on rbi_pkg for the command and status structs.
module rbi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              res_full,
  output rbi_pkg::rbi_cmd_t cmd,
  input  rbi_pkg::rbi_sts_t sts
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDec   = 4'd1;
  localparam logic [3:0] StScan  = 4'd2;
  localparam logic [3:0] StDiv   = 4'd3;
  localparam logic [3:0] StRd0   = 4'd4;
  localparam logic [3:0] StRd1   = 4'd5;
  localparam logic [3:0] StRd2   = 4'd6;
  localparam logic [3:0] StRd3   = 4'd7;
  localparam logic [3:0] StLerp0 = 4'd8;
  localparam logic [3:0] StLerp1 = 4'd9;
  localparam logic [3:0] StLerp2 = 4'd10;
  localparam logic [3:0] StDone  = 4'd11;
  localparam logic [3:0] StWait  = 4'd12;

  logic [3:0] state_r, state_nxt;

  // Accept a request only when idle; the result register decouples the output.
  assign in_stall = (state_r != StIdle);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = StDec;
        end
      end
      StDec: begin
        if (!sts.is_query) begin
          if (!res_full) begin
            cmd.do_load = 1'b1;
            state_nxt = StIdle;
          end
        end else if (!sts.var_ok) begin
          state_nxt = StWait;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = StScan;
        end
      end
      StScan: begin
        if (sts.scan_done) begin
          if (sts.found_both) begin
            cmd.div_start = 1'b1;
            state_nxt = StDiv;
          end else begin
            state_nxt = StWait;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      StDiv: begin
        if (sts.div_done) begin
          cmd.rd_corner = 1'b1;
          cmd.corner = 2'd0;
          state_nxt = StRd0;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      StRd0: begin
        cmd.rd_corner = 1'b1;
        cmd.corner = 2'd1;
        state_nxt = StRd1;
      end
      StRd1: begin
        cmd.rd_corner = 1'b1;
        cmd.corner = 2'd2;
        state_nxt = StRd2;
      end
      StRd2: begin
        cmd.rd_corner = 1'b1;
        cmd.corner = 2'd3;
        state_nxt = StRd3;
      end
      StRd3: begin
        state_nxt = StLerp0;
      end
      StLerp0: begin
        cmd.lerp_row = 1'b1;
        cmd.lerp_sel = 2'd0;
        state_nxt = StLerp1;
      end
      StLerp1: begin
        cmd.lerp_row = 1'b1;
        cmd.lerp_sel = 2'd1;
        state_nxt = StLerp2;
      end
      StLerp2: begin
        cmd.lerp_row = 1'b1;
        cmd.lerp_sel = 2'd2;
        state_nxt = StDone;
      end
      StDone: begin
        if (!res_full) begin
          cmd.finish = 1'b1;
          state_nxt = StIdle;
        end
      end
      StWait: begin
        if (!res_full) begin
          cmd.fail = 1'b1;
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // Only one result-producing command fires per cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_load, cmd.finish, cmd.fail}))
    else $error("rbi_ctrl: multiple result commands");
  // Results are never produced into a full result register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_load || cmd.finish || cmd.fail) |-> !res_full)
    else $error("rbi_ctrl: result overrun");
  // A capture always moves the controller to decode.
  a_cap_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == StDec))
    else $error("rbi_ctrl: capture without decode");
`endif

endmodule

### design/rbi_dp.sv
// Datapath of the interpolator: coordinate and grid memories, bracket scan,
// serial dividers and the shared blend unit. Depends on rbi_pkg.
module rbi_dp #(
  parameter int MAX_X      = rbi_pkg::MaxXDef,
  parameter int MAX_Y      = rbi_pkg::MaxYDef,
  parameter int NUM_FIELDS = rbi_pkg::NumFieldsDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [rbi_pkg::CountW-1:0]        cfg_data,
  input  logic [1:0]                        in_op,
  input  logic [rbi_pkg::IdxW-1:0]          in_x_index,
  input  logic [rbi_pkg::IdxW-1:0]          in_y_index,
  input  logic [rbi_pkg::VarW-1:0]          in_var_index,
  input  logic signed [rbi_pkg::ValW-1:0]   in_load_value,
  input  logic signed [rbi_pkg::CrdW-1:0]   in_query_x,
  input  logic signed [rbi_pkg::CrdW-1:0]   in_query_y,
  input  rbi_pkg::rbi_cmd_t                 cmd,
  output rbi_pkg::rbi_sts_t                 sts,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              res_full,
  output logic signed [rbi_pkg::ValW-1:0]   out_field_value,
  output logic                              out_in_range
);

  localparam int XW   = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int VW   = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
  localparam int XCW  = $clog2(MAX_X + 1);
  localparam int YCW  = $clog2(MAX_Y + 1);
  localparam int GD   = NUM_FIELDS * MAX_Y * MAX_X;
  localparam int GW   = $clog2(GD);
  localparam int CW   = rbi_pkg::CrdW;
  localparam int VLW  = rbi_pkg::ValW;
  localparam int IW   = rbi_pkg::IdxW;
  localparam int NW   = CW + 1 + 16;  // shifted numerator width

  // Configuration registers.
  logic [rbi_pkg::CountW-1:0] x_count_r, y_count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_count_r <= rbi_pkg::CountW'(2);
      y_count_r <= rbi_pkg::CountW'(2);
    end else if (cfg_we) begin
      if (cfg_index == rbi_pkg::CfgXCount) x_count_r <= cfg_data;
      else y_count_r <= cfg_data;
    end
  end

  // Clamped counts.
  logic [XCW-1:0] nx;
  logic [YCW-1:0] ny;
  assign nx = (32'(x_count_r) > MAX_X) ? XCW'(MAX_X) : XCW'(x_count_r);
  assign ny = (32'(y_count_r) > MAX_Y) ? YCW'(MAX_Y) : YCW'(y_count_r);

  // Captured request.
  logic [1:0]           op_r;
  logic [IW-1:0]        xi_r, yi_r;
  logic [rbi_pkg::VarW-1:0] vi_r;
  logic signed [VLW-1:0] lv_r;
  logic signed [CW-1:0]  qx_r, qy_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      xi_r <= in_x_index;
      yi_r <= in_y_index;
      vi_r <= in_var_index;
      lv_r <= in_load_value;
      qx_r <= in_query_x;
      qy_r <= in_query_y;
    end
  end

  logic x_ok, y_ok, v_ok;
  assign x_ok = 32'(xi_r) < MAX_X;
  assign y_ok = 32'(yi_r) < MAX_Y;
  assign v_ok = 32'(vi_r) < NUM_FIELDS;

  // Scan counters; both axes walk in parallel.
  logic [XCW-1:0] sx_r;
  logic [YCW-1:0] sy_r;
  logic           fx_r, fy_r;
  logic [XW-1:0]  bx_r;
  logic [YW-1:0]  by_r;
  logic signed [CW-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic           rd_vld_r;
  logic           more;

  // Coordinate memories, read at two addresses each through two copies.
  logic signed [CW-1:0] xmem_a [MAX_X];
  logic signed [CW-1:0] xmem_b [MAX_X];
  logic signed [CW-1:0] ymem_a [MAX_Y];
  logic signed [CW-1:0] ymem_b [MAX_Y];
  logic signed [CW-1:0] xa_q, xb_q, ya_q, yb_q;

  logic wr_x, wr_y, wr_g;
  assign wr_x = cmd.do_load && op_r == rbi_pkg::OpLoadX && x_ok;
  assign wr_y = cmd.do_load && op_r == rbi_pkg::OpLoadY && y_ok;
  assign wr_g = cmd.do_load && op_r == rbi_pkg::OpLoadV && x_ok && y_ok && v_ok;

  logic [XW-1:0] xra, xrb;
  logic [YW-1:0] yra, yrb;
  logic [XW:0]   xnx;
  logic [YW:0]   ynx;
  assign xnx = (XW+1)'(sx_r) + 1'b1;
  assign ynx = (YW+1)'(sy_r) + 1'b1;
  assign xra = sx_r[XW-1:0];
  assign xrb = xnx[XW-1:0];
  assign yra = sy_r[YW-1:0];
  assign yrb = ynx[YW-1:0];

  // Coordinate memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_x) begin
      xmem_a[XW'(xi_r)] <= lv_r[CW-1:0];
      xmem_b[XW'(xi_r)] <= lv_r[CW-1:0];
    end
    if (wr_y) begin
      ymem_a[YW'(yi_r)] <= lv_r[CW-1:0];
      ymem_b[YW'(yi_r)] <= lv_r[CW-1:0];
    end
    xa_q <= xmem_a[xra];
    xb_q <= xmem_b[xrb];
    ya_q <= ymem_a[yra];
    yb_q <= ymem_b[yrb];
  end

  // Pair under test is live when its upper index is below the count.
  logic xlive, ylive, xlive_r, ylive_r;
  logic [XW-1:0] xcur_r;
  logic [YW-1:0] ycur_r;
  assign xlive = 32'(xnx) < 32'(nx);
  assign ylive = 32'(ynx) < 32'(ny);

  logic xhit, yhit;
  assign xhit = rd_vld_r && xlive_r && !fx_r && (xa_q <= qx_r) && (xb_q > qx_r);
  assign yhit = rd_vld_r && ylive_r && !fy_r && (ya_q <= qy_r) && (yb_q > qy_r);

  // Bracket scan: one coordinate pair per axis each cycle. A read is only
  // checked when some axis still had a live, unfound pair when it was issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step && more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      sx_r <= '0;
      sy_r <= '0;
      fx_r <= 1'b0;
      fy_r <= 1'b0;
    end else if (cmd.scan_step || rd_vld_r) begin
      if (cmd.scan_step) begin
        if (xlive) sx_r <= sx_r + 1'b1;
        if (ylive) sy_r <= sy_r + 1'b1;
        xlive_r <= xlive;
        ylive_r <= ylive;
        xcur_r <= xra;
        ycur_r <= yra;
      end
      if (xhit) begin
        fx_r <= 1'b1;
        bx_r <= xcur_r;
        xlo_r <= xa_q;
        xhi_r <= xb_q;
      end
      if (yhit) begin
        fy_r <= 1'b1;
        by_r <= ycur_r;
        ylo_r <= ya_q;
        yhi_r <= yb_q;
      end
    end
  end

  assign more = (xlive && !fx_r) || (ylive && !fy_r);
  assign sts.scan_done = !rd_vld_r && !more ? 1'b1 : 1'b0;
  assign sts.found_both = fx_r && fy_r;
  assign sts.is_query = (op_r == rbi_pkg::OpInterp);
  assign sts.var_ok = v_ok;

  // Two restoring dividers, one quotient bit per cycle.
  logic [NW-1:0] remx_r, remy_r;
  logic [CW:0]   denx_r, deny_r;
  logic [15:0]   qtx_r, qty_r;
  logic [4:0]    dcnt_r;
  logic [CW:0]   nxm, nym, dxm, dym;
  assign nxm = (CW+1)'(qx_r) - (CW+1)'(xlo_r);
  assign nym = (CW+1)'(qy_r) - (CW+1)'(ylo_r);
  assign dxm = (CW+1)'(xhi_r) - (CW+1)'(xlo_r);
  assign dym = (CW+1)'(yhi_r) - (CW+1)'(ylo_r);

  logic [NW:0] trx, try_;
  assign trx  = {remx_r, 1'b0} - {{(NW-CW){1'b0}}, denx_r};
  assign try_ = {remy_r, 1'b0} - {{(NW-CW){1'b0}}, deny_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      remx_r <= NW'(nxm);
      remy_r <= NW'(nym);
      denx_r <= dxm;
      deny_r <= dym;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      // Remainder stays below the divisor, so it fits before doubling.
      if (!trx[NW]) begin
        remx_r <= trx[NW-1:0];
        qtx_r <= {qtx_r[14:0], 1'b1};
      end else begin
        remx_r <= {remx_r[NW-2:0], 1'b0};
        qtx_r <= {qtx_r[14:0], 1'b0};
      end
      if (!try_[NW]) begin
        remy_r <= try_[NW-1:0];
        qty_r <= {qty_r[14:0], 1'b1};
      end else begin
        remy_r <= {remy_r[NW-2:0], 1'b0};
        qty_r <= {qty_r[14:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 1'b1;
    end
  end
  // The first comparison has the quotient bit below 1 since num < den.
  assign sts.div_done = (dcnt_r == 5'd16);

  // Grid memory, single port, registered read.
  logic signed [VLW-1:0] gmem [GD];
  logic signed [VLW-1:0] g_q;
  logic [GW-1:0] gaddr;
  logic [XW-1:0] cxi;
  logic [YW-1:0] cyi;
  logic [XW:0]   bx1;
  logic [YW:0]   by1;
  assign bx1 = (XW+1)'(bx_r) + 1'b1;
  assign by1 = (YW+1)'(by_r) + 1'b1;
  assign cxi = cmd.corner[0] ? bx1[XW-1:0] : bx_r;
  assign cyi = cmd.corner[1] ? by1[YW-1:0] : by_r;

  always_comb begin
    if (wr_g) begin
      gaddr = GW'((32'(VW'(vi_r)) * MAX_Y + 32'(YW'(yi_r))) * MAX_X
                  + 32'(XW'(xi_r)));
    end else begin
      gaddr = GW'((32'(VW'(vi_r)) * MAX_Y + 32'(cyi)) * MAX_X + 32'(cxi));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_g) gmem[gaddr] <= lv_r;
    g_q <= gmem[gaddr];
  end

  // Corner capture: reads issued at corners 0..3 land in the following cycle.
  logic signed [VLW-1:0] c_r [4];
  logic [1:0] cidx_r;
  logic       cv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cv_r <= 1'b0;
    else cv_r <= cmd.rd_corner;
    cidx_r <= cmd.corner;
    if (cv_r) c_r[cidx_r] <= g_q;
  end

  // Shared blend unit: a + round((b - a) * f / 65536), one per cycle.
  logic signed [VLW-1:0] la, lb, r0_r, r1_r, res_r;
  logic [15:0] lf;
  always_comb begin
    case (cmd.lerp_sel)
      2'd0: begin la = c_r[0]; lb = c_r[1]; lf = qtx_r; end
      2'd1: begin la = c_r[2]; lb = c_r[3]; lf = qtx_r; end
      default: begin la = r0_r; lb = r1_r; lf = qty_r; end
    endcase
  end
  logic signed [VLW:0]    ldiff;
  logic signed [VLW+17:0] lprod;
  logic signed [VLW:0]    lsum;
  assign ldiff = (VLW+1)'(lb) - (VLW+1)'(la);
  assign lprod = ldiff * $signed({1'b0, lf}) + (VLW+18)'(32768);
  assign lsum  = (VLW+1)'(la) + (VLW+1)'(lprod >>> 16);

  always_ff @(posedge clk) begin
    if (cmd.lerp_row) begin
      case (cmd.lerp_sel)
        2'd0: r0_r <= lsum[VLW-1:0];
        2'd1: r1_r <= lsum[VLW-1:0];
        default: res_r <= lsum[VLW-1:0];
      endcase
    end
  end

  // Output register.
  logic ov_r;
  logic signed [VLW-1:0] ofv_r;
  logic oir_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.do_load || cmd.finish || cmd.fail) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.do_load) begin
      ofv_r <= '0;
      oir_r <= wr_x || wr_y || wr_g;
    end else if (cmd.finish) begin
      ofv_r <= res_r;
      oir_r <= 1'b1;
    end else if (cmd.fail) begin
      ofv_r <= '0;
      oir_r <= 1'b0;
    end
  end
  assign out_valid = ov_r;
  assign res_full = ov_r && out_stall;
  assign out_field_value = ofv_r;
  assign out_in_range = oir_r;

`ifndef SYNTHESIS
  // A found x bracket has a strictly positive span.
  a_span_x: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_start) |-> (xhi_r > xlo_r))
    else $error("rbi_dp: empty x span");
  // The divider runs exactly sixteen steps before corner reads.
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_corner && cmd.corner == 2'd0) |-> (dcnt_r == 5'd16))
    else $error("rbi_dp: divider not finished");
  // A grid write and a corner read never share the port.
  a_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_g && cmd.rd_corner))
    else $error("rbi_dp: grid port conflict");
`endif

endmodule

### design/rectilinear_bilinear_interpolator_unit.sv
// Top level of the rectilinear bilinear interpolator.
// Joins rbi_ctrl and rbi_dp; depends on rbi_pkg.
//
// Usage: requests enter on the in_ channel (valid/stall), one at a time.
// Ops 0..2 load an x coordinate, a y coordinate or a grid value; op 3
// interpolates variable var_index at (query_x, query_y). Each request makes
// exactly one result on the out_ channel: field_value and in_range.
// A load is written from the decode state once the output register is free.
// A query walks both axes at once, one pair per cycle, then runs both
// fraction dividers, reads the four corners and blends them into the result.
// The next request is taken once the previous result is in the output
// register. Configuration (cfg_we, cfg_index, cfg_data) writes x_count or
// y_count; the user must write it only while the block is idle, since the
// block itself does not enforce this.
// Reset: the controller returns to idle, the output goes invalid and both
// counts become 2. Memories are undefined until loaded; no clearing pass.
// When the receiver stalls, the result is held in the output register and
// the block finishes at most one further request's work before waiting.
module rectilinear_bilinear_interpolator_unit #(
  parameter int MAX_X      = rbi_pkg::MaxXDef,
  parameter int MAX_Y      = rbi_pkg::MaxYDef,
  parameter int NUM_FIELDS = rbi_pkg::NumFieldsDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [rbi_pkg::CountW-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_op,
  input  logic [rbi_pkg::IdxW-1:0]          in_x_index,
  input  logic [rbi_pkg::IdxW-1:0]          in_y_index,
  input  logic [rbi_pkg::VarW-1:0]          in_var_index,
  input  logic signed [rbi_pkg::ValW-1:0]   in_load_value,
  input  logic signed [rbi_pkg::CrdW-1:0]   in_query_x,
  input  logic signed [rbi_pkg::CrdW-1:0]   in_query_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rbi_pkg::ValW-1:0]   out_field_value,
  output logic                              out_in_range
);

  rbi_pkg::rbi_cmd_t cmd;
  rbi_pkg::rbi_sts_t sts;
  logic              res_full;

  // Controller.
  rbi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .res_full (res_full),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath.
  rbi_dp #(
    .MAX_X      (MAX_X),
    .MAX_Y      (MAX_Y),
    .NUM_FIELDS (NUM_FIELDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_op           (in_op),
    .in_x_index      (in_x_index),
    .in_y_index      (in_y_index),
    .in_var_index    (in_var_index),
    .in_load_value   (in_load_value),
    .in_query_x      (in_query_x),
    .in_query_y      (in_query_y),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .res_full        (res_full),
    .out_field_value (out_field_value),
    .out_in_range    (out_in_range)
  );

endmodule
